// ===== src/bcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bcsm_pkg
// Shared types and constants for the banked cartridge SRAM mapper.
// ----------------------------------------------------------------------------
package bcsm_pkg;

  localparam int unsigned SramAddrW = 15;
  localparam int unsigned SramDepth = 1 << SramAddrW;
  localparam int unsigned BankW     = 5;

  // Bus access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // IO1 register offsets (address low bits)
  localparam logic [1:0] REG_BANK = 2'd2;
  localparam logic [1:0] REG_CTRL = 2'd3;

  // Control byte bit positions
  localparam int unsigned CtrlIoDisBit = 3;
  localparam int unsigned CtrlSramWeBit = 4;
  localparam int unsigned CtrlMappedBit = 5;
  localparam int unsigned CtrlGameBit   = 6;
  localparam int unsigned CtrlExromBit  = 7;

  // Address windows (upper address bits)
  localparam logic [2:0] WIN_4000 = 3'b010;
  localparam logic [2:0] WIN_6000 = 3'b011;
  localparam logic [2:0] WIN_8000 = 3'b100;
  localparam logic [2:0] WIN_A000 = 3'b101;
  localparam logic [2:0] WIN_E000 = 3'b111;
  localparam logic [7:0] PAGE_DE  = 8'hDE;
  localparam logic [7:0] PAGE_DF  = 8'hDF;
  localparam logic [6:0] IO_WIN   = 7'b1101111;  // $DE00-$DFFF
  localparam logic [4:0] IO_BASE  = 5'h1F;       // top 512 bytes of a 16K half

  typedef enum logic [1:0] {
    MODE_16K     = 2'd0,
    MODE_8K      = 2'd1,
    MODE_ULTIMAX = 2'd2,
    MODE_OFF     = 2'd3
  } bcsm_mode_e;

  typedef struct packed {
    logic                 re;
    logic                 we;
    logic [SramAddrW-1:0] addr;
    logic [7:0]           wdata;
  } bcsm_sram_req_t;

  typedef struct packed {
    bcsm_sram_req_t   req;
    logic             use_mem;     // read data comes from SRAM
    logic [7:0]       alt_data;    // read data otherwise
    logic             drives_bus;
    logic             write_route;
    logic             sram_stored;
    logic             game;
    logic             exrom;
    bcsm_mode_e       mode;
    logic [BankW-1:0] bank;
  } bcsm_dec_t;

endpackage

// ===== src/bcsm_regs.sv =====
// ----------------------------------------------------------------------------
// bcsm_regs
// Bank and control registers plus the address decode of one bus transaction.
// ----------------------------------------------------------------------------
module bcsm_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        opcode_i,
  input  logic [15:0]                 bus_address_i,
  input  logic [7:0]                  write_data_i,
  input  logic [7:0]                  open_bus_value_i,
  output bcsm_pkg::bcsm_dec_t         dec_o
);

  logic [bcsm_pkg::BankW-1:0] bank_q, bank_d;
  logic iodis_q, iodis_d, sramwe_q, sramwe_d, mapped_q, mapped_d;
  logic game_q, game_d, exrom_q, exrom_d;

  logic [2:0] win;
  logic       r45, r67, r89, rab, ref_w, io_win, pg_de, pg_df;
  logic       is_wr, reg_hit, bank_wr, ctrl_wr, io_st, low_st, high_st;
  logic       b;
  logic [bcsm_pkg::SramAddrW-1:0] low_off, high_off, io_off;
  bcsm_pkg::bcsm_mode_e mode_n;

  always_comb begin
    win    = bus_address_i[15:13];
    r45    = (win == bcsm_pkg::WIN_4000);
    r67    = (win == bcsm_pkg::WIN_6000);
    r89    = (win == bcsm_pkg::WIN_8000);
    rab    = (win == bcsm_pkg::WIN_A000);
    ref_w  = (win == bcsm_pkg::WIN_E000);
    io_win = (bus_address_i[15:9] == bcsm_pkg::IO_WIN);
    pg_de  = (bus_address_i[15:8] == bcsm_pkg::PAGE_DE);
    pg_df  = (bus_address_i[15:8] == bcsm_pkg::PAGE_DF);
    b      = bank_q[0];

    low_off  = {b, 1'b0, bus_address_i[12:0]};
    high_off = {b, 1'b1, bus_address_i[12:0]};
    io_off   = {b, bcsm_pkg::IO_BASE, bus_address_i[8:0]};

    is_wr   = (opcode_i == bcsm_pkg::OP_WRITE);
    reg_hit = is_wr && !iodis_q && pg_de;
    bank_wr = reg_hit && (bus_address_i[1:0] == bcsm_pkg::REG_BANK);
    ctrl_wr = reg_hit && (bus_address_i[1:0] == bcsm_pkg::REG_CTRL);

    io_st   = is_wr && !bank_wr && !ctrl_wr && sramwe_q && !mapped_q &&
              (pg_df || (iodis_q && pg_de));
    low_st  = is_wr && !bank_wr && !ctrl_wr && !io_st && sramwe_q && (r45 || r89);
    high_st = is_wr && !bank_wr && !ctrl_wr && !io_st && sramwe_q && (r67 || rab);

    // Next register state
    bank_d   = bank_q;
    iodis_d  = iodis_q;
    sramwe_d = sramwe_q;
    mapped_d = mapped_q;
    game_d   = game_q;
    exrom_d  = exrom_q;
    if (bank_wr) begin
      bank_d = write_data_i[bcsm_pkg::BankW-1:0];
    end
    if (ctrl_wr) begin
      iodis_d  = write_data_i[bcsm_pkg::CtrlIoDisBit];
      sramwe_d = write_data_i[bcsm_pkg::CtrlSramWeBit];
      mapped_d = write_data_i[bcsm_pkg::CtrlMappedBit];
      game_d   = write_data_i[bcsm_pkg::CtrlGameBit];
      exrom_d  = write_data_i[bcsm_pkg::CtrlExromBit];
    end
    mode_n = bcsm_pkg::bcsm_mode_e'({exrom_d, game_d});

    // SRAM request, decided on the state before the transaction
    dec_o.req.wdata = write_data_i;
    dec_o.req.we    = io_st || low_st || high_st;
    dec_o.use_mem   = 1'b0;
    dec_o.req.addr  = low_off;
    if (is_wr) begin
      priority if (io_st) begin
        dec_o.req.addr = io_off;
      end else if (high_st) begin
        dec_o.req.addr = high_off;
      end else begin
        dec_o.req.addr = low_off;
      end
    end else begin
      priority if (mapped_q && r89) begin
        dec_o.use_mem  = 1'b1;
        dec_o.req.addr = low_off;
      end else if (mapped_q && (rab || ref_w)) begin
        dec_o.use_mem  = 1'b1;
        dec_o.req.addr = high_off;
      end else if (io_win) begin
        dec_o.use_mem  = 1'b1;
        dec_o.req.addr = io_off;
      end else begin
        dec_o.use_mem  = 1'b0;
      end
    end
    dec_o.req.re   = dec_o.use_mem;
    dec_o.alt_data = is_wr ? 8'h00 : open_bus_value_i;

    // Reported decodes use the state after the transaction
    dec_o.drives_bus = io_win;
    if (!io_win && mapped_d) begin
      unique case (mode_n)
        bcsm_pkg::MODE_16K:     dec_o.drives_bus = r89 || rab;
        bcsm_pkg::MODE_8K:      dec_o.drives_bus = r89;
        bcsm_pkg::MODE_ULTIMAX: dec_o.drives_bus = r89 || ref_w;
        default:                dec_o.drives_bus = 1'b0;
      endcase
    end
    dec_o.write_route = sramwe_d && (r45 || r67 || r89 || rab);
    dec_o.sram_stored = dec_o.req.we;
    dec_o.game        = game_d;
    dec_o.exrom       = exrom_d;
    dec_o.mode        = mode_n;
    dec_o.bank        = bank_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q   <= '0;
      iodis_q  <= 1'b0;
      sramwe_q <= 1'b0;
      mapped_q <= 1'b0;
      game_q   <= 1'b0;
      exrom_q  <= 1'b0;
    end else if (accept_i) begin
      bank_q   <= bank_d;
      iodis_q  <= iodis_d;
      sramwe_q <= sramwe_d;
      mapped_q <= mapped_d;
      game_q   <= game_d;
      exrom_q  <= exrom_d;
    end
  end

endmodule

// ===== src/bcsm_sram.sv =====
// ----------------------------------------------------------------------------
// bcsm_sram
// 32 KiB single-port SRAM with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module bcsm_sram (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  bcsm_pkg::bcsm_sram_req_t req_i,
  output logic [7:0]             rdata_o,
  output logic                   busy_o
);

  logic [7:0] mem [bcsm_pkg::SramDepth];
  logic [7:0] rdata_q;
  logic       busy_q, busy_d;
  logic [bcsm_pkg::SramAddrW-1:0] clr_q, clr_d;
  logic       wr_en;
  logic [bcsm_pkg::SramAddrW-1:0] wr_addr;
  logic [7:0] wr_data;

  always_comb begin
    clr_d  = clr_q + 1'b1;
    busy_d = busy_q && (clr_q != '1);
    if (busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = 8'h00;
    end else begin
      wr_en   = req_valid_i && req_i.we;
      wr_addr = req_i.addr;
      wr_data = req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      busy_q <= busy_d;
      clr_q  <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req_valid_i && req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

// ===== src/banked_cartridge_sram_mapper_unit.sv =====
// Pipeline: an accepted transaction enters stage 1 with its SRAM access, then the
//   output register, which raises out_valid_o; a result stall can hold either one.
// Throughput: one transaction per cycle while in_stall_o is low; the single SRAM
//   port is read or written once, at the accept edge, so back-to-back transactions
//   never collide. Reset: bank and control flags clear at once; the SRAM then
//   sweeps all 32768 bytes to zero, one per cycle, holding in_stall_o high until done.
// ----------------------------------------------------------------------------
// banked_cartridge_sram_mapper_unit
// Cartridge mapper with a 5-bit bank register, control flags and a 32 KiB
// SRAM window. One bus transaction in, one result transaction out.
// ----------------------------------------------------------------------------
module banked_cartridge_sram_mapper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  open_bus_value_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        drives_bus_o,
  output logic        write_route_o,
  output logic        sram_stored_o,
  output logic        game_line_o,
  output logic        exrom_line_o,
  output logic [1:0]  memory_mode_o,
  output logic [4:0]  rom_bank_o
);

  logic                accept;
  logic                sram_busy;
  logic [7:0]          sram_rdata;
  bcsm_pkg::bcsm_dec_t dec;

  // Stage 1: decode results waiting for the SRAM read data
  logic                s1_valid_q, s1_valid_d;
  bcsm_pkg::bcsm_dec_t s1_q;
  logic                s1_adv;
  logic [7:0]          s1_rdata;

  // Stage 2: output register
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_rdata_q;
  bcsm_pkg::bcsm_dec_t out_q;

  // Advance stage 1 whenever the output register is free or being drained.
  // Stall intake while stage 1 is stuck or the SRAM sweep is running; the read
  // data register only loads on accept, so it holds while stage 1 waits.
  always_comb begin
    s1_adv      = s1_valid_q && (!out_valid_q || !out_stall_i);
    in_stall_o  = sram_busy || (s1_valid_q && !s1_adv);
    accept      = in_valid_i && !in_stall_o;
    s1_valid_d  = accept || (s1_valid_q && !s1_adv);
    out_valid_d = s1_adv || (out_valid_q && out_stall_i);
    s1_rdata    = s1_q.use_mem ? sram_rdata : s1_q.alt_data;
  end

  bcsm_regs u_regs (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .opcode_i         (opcode_i),
    .bus_address_i    (bus_address_i),
    .write_data_i     (write_data_i),
    .open_bus_value_i (open_bus_value_i),
    .dec_o            (dec)
  );

  bcsm_sram u_sram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (accept),
    .req_i       (dec.req),
    .rdata_o     (sram_rdata),
    .busy_o      (sram_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on advance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= dec;
    end
    if (s1_adv) begin
      out_q       <= s1_q;
      out_rdata_q <= s1_rdata;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_rdata_q;
  assign drives_bus_o  = out_q.drives_bus;
  assign write_route_o = out_q.write_route;
  assign sram_stored_o = out_q.sram_stored;
  assign game_line_o   = out_q.game;
  assign exrom_line_o  = out_q.exrom;
  assign memory_mode_o = out_q.mode;
  assign rom_bank_o    = out_q.bank;

  // No transaction enters while the SRAM sweep runs
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sram_busy |-> !accept)
    else $error("transaction accepted during SRAM clear sweep");

  // A stalled stage 1 keeps its transaction
  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |=> s1_valid_q)
    else $error("stage 1 transaction dropped under stall");

  // A stored write never returns read data
  a_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.sram_stored) |-> (out_rdata_q == 8'h00))
    else $error("stored write reported nonzero read data");

  // Reported mode follows the GAME and EXROM lines
  a_mode_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (memory_mode_o == {out_q.exrom, out_q.game}))
    else $error("memory mode disagrees with GAME/EXROM lines");

endmodule

// ===== sim/tb_banked_cartridge_sram_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// tb_banked_cartridge_sram_mapper_unit
// Self-checking bench for the cartridge SRAM mapper. A short table of bus
// transactions walks the register writes, every window and the mode-dependent
// drive rules. Random reads and writes follow, aimed at the mapped windows so
// that stored bytes are read back. Every result is compared field by field
// against a cycle-free model of the bank, the control flags and the SRAM.
// ----------------------------------------------------------------------------
module tb_banked_cartridge_sram_mapper_unit;

  localparam int unsigned NumRandom     = 900;
  localparam int unsigned HoldoffCycles = 300;     // long result-side hold-off
  localparam int unsigned DrainCycles   = 8;       // edges watched for stray results after draining
  localparam int unsigned StallLimit    = 150000;  // long enough to cover the SRAM clear sweep

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  obus;
  } bus_access_t;

  typedef struct packed {
    logic [7:0]           read_data;
    logic                 drives_bus;
    logic                 write_route;
    logic                 sram_stored;
    logic                 game;
    logic                 exrom;
    bcsm_pkg::bcsm_mode_e mode;
    logic [4:0]           bank;
  } bus_result_t;

  typedef struct {
    logic        typed;  // expected result typed in below
    bus_access_t acc;
    bus_result_t res;
  } vector_row_t;

  // DUT ports; drive every input to a known value from time zero
  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic        opcode_i         = bcsm_pkg::OP_READ;
  logic [15:0] bus_address_i    = '0;
  logic [7:0]  write_data_i     = '0;
  logic [7:0]  open_bus_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [7:0]  read_data_o;
  logic        drives_bus_o;
  logic        write_route_o;
  logic        sram_stored_o;
  logic        game_line_o;
  logic        exrom_line_o;
  logic [1:0]  memory_mode_o;
  logic [4:0]  rom_bank_o;

  // Model state: bank, control flags and a mirror of the SRAM
  logic [4:0] bank_q    = '0;
  logic       io_dis_q  = 1'b0;
  logic       we_q      = 1'b0;
  logic       mapped_q  = 1'b0;
  logic       game_q    = 1'b0;
  logic       exrom_q   = 1'b0;
  logic [7:0] sram_mirror [bcsm_pkg::SramDepth];

  bus_result_t expected_bus_results [$];
  vector_row_t directed_rows [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned phase         = 0;
  int unsigned holdoff_left  = 0;
  bit          holdoff_done  = 1'b0;
  int unsigned idle_cycles   = 0;
  int unsigned mismatches    = 0;
  int unsigned reads_seen    = 0;
  int unsigned writes_seen   = 0;
  int unsigned stored_seen   = 0;

  banked_cartridge_sram_mapper_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .bus_address_i    (bus_address_i),
    .write_data_i     (write_data_i),
    .open_bus_value_i (open_bus_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_data_o      (read_data_o),
    .drives_bus_o     (drives_bus_o),
    .write_route_o    (write_route_o),
    .sram_stored_o    (sram_stored_o),
    .game_line_o      (game_line_o),
    .exrom_line_o     (exrom_line_o),
    .memory_mode_o    (memory_mode_o),
    .rom_bank_o       (rom_bank_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Apply one bus access to the model and return the result it produces.
  // Offsets are taken from the bank as it stood before the access; a register
  // write never stores, so a bank change cannot reach this access's offsets.
  function automatic bus_result_t predict_bus_access(input bus_access_t a);
    bus_result_t r;
    logic [14:0] half;
    logic [14:0] low_off;
    logic [14:0] high_off;
    logic [14:0] io_off;
    logic [2:0]  win;
    logic        in_io;
    logic        in_de;
    logic        reg_hit;
    logic        mode_drive;
    half     = bank_q[0] ? 15'h4000 : 15'h0000;
    low_off  = {2'b00, a.addr[12:0]} + half;
    high_off = {2'b00, a.addr[12:0]} + 15'h2000 + half;
    io_off   = 15'h3E00 + {6'd0, a.addr[8:0]} + half;
    win      = a.addr[15:13];
    in_io    = a.addr[15:9] == bcsm_pkg::IO_WIN;
    in_de    = a.addr[15:8] == bcsm_pkg::PAGE_DE;
    reg_hit  = 1'b0;
    r        = '0;

    if (a.op == bcsm_pkg::OP_READ) begin
      reads_seen++;
      // Mapped SRAM wins over the IO window; otherwise fall back to open bus
      if (mapped_q && win == bcsm_pkg::WIN_8000)
        r.read_data = sram_mirror[low_off];
      else if (mapped_q && (win == bcsm_pkg::WIN_A000 || win == bcsm_pkg::WIN_E000))
        r.read_data = sram_mirror[high_off];
      else if (in_io)
        r.read_data = sram_mirror[io_off];
      else
        r.read_data = a.obus;
    end else begin
      writes_seen++;
      if (!io_dis_q && in_de && a.addr[1:0] == bcsm_pkg::REG_BANK) begin
        bank_q  = a.wdata[4:0];
        reg_hit = 1'b1;
      end else if (!io_dis_q && in_de && a.addr[1:0] == bcsm_pkg::REG_CTRL) begin
        io_dis_q = a.wdata[bcsm_pkg::CtrlIoDisBit];
        we_q     = a.wdata[bcsm_pkg::CtrlSramWeBit];
        mapped_q = a.wdata[bcsm_pkg::CtrlMappedBit];
        game_q   = a.wdata[bcsm_pkg::CtrlGameBit];
        exrom_q  = a.wdata[bcsm_pkg::CtrlExromBit];
        reg_hit  = 1'b1;
      end
      // Other IO1 offsets fall through to the SRAM store rules
      if (!reg_hit && we_q) begin
        if (!mapped_q && (a.addr[15:8] == bcsm_pkg::PAGE_DF || (io_dis_q && in_de))) begin
          sram_mirror[io_off] = a.wdata;
          r.sram_stored       = 1'b1;
        end else if (win == bcsm_pkg::WIN_4000 || win == bcsm_pkg::WIN_8000) begin
          sram_mirror[low_off] = a.wdata;
          r.sram_stored        = 1'b1;
        end else if (win == bcsm_pkg::WIN_6000 || win == bcsm_pkg::WIN_A000) begin
          sram_mirror[high_off] = a.wdata;
          r.sram_stored         = 1'b1;
        end
      end
      if (r.sram_stored) stored_seen++;
    end

    // Decodes reflect the state after the access, on reads and writes alike
    r.mode = bcsm_pkg::bcsm_mode_e'({exrom_q, game_q});
    case (r.mode)
      bcsm_pkg::MODE_16K:
        mode_drive = win == bcsm_pkg::WIN_8000 || win == bcsm_pkg::WIN_A000;
      bcsm_pkg::MODE_8K:
        mode_drive = win == bcsm_pkg::WIN_8000;
      bcsm_pkg::MODE_ULTIMAX:
        mode_drive = win == bcsm_pkg::WIN_8000 || win == bcsm_pkg::WIN_E000;
      default:
        mode_drive = 1'b0;
    endcase
    r.drives_bus  = in_io || (mapped_q && mode_drive);
    r.write_route = we_q && a.addr >= 16'h4000 && a.addr <= 16'hBFFF;
    r.game        = game_q;
    r.exrom       = exrom_q;
    r.bank        = bank_q;
    return r;
  endfunction

  function automatic vector_row_t plain_row(input logic op, input logic [15:0] addr,
                                            input logic [7:0] wdata, input logic [7:0] obus);
    vector_row_t row;
    row.typed = 1'b0;
    row.acc   = '{op, addr, wdata, obus};
    row.res   = '0;
    return row;
  endfunction

  function automatic vector_row_t known_row(input logic op, input logic [15:0] addr,
                                            input logic [7:0] wdata, input logic [7:0] obus,
                                            input logic [7:0] rdata, input logic drv,
                                            input logic route, input logic stored,
                                            input bcsm_pkg::bcsm_mode_e mode,
                                            input logic [4:0] bank);
    vector_row_t row;
    row           = plain_row(op, addr, wdata, obus);
    row.typed     = 1'b1;
    row.res       = '{rdata, drv, route, stored, mode[0], mode[1], mode, bank};
    return row;
  endfunction

  // Bias offsets toward the window edges and a small cluster at the bottom,
  // so writes and later reads land on the same bytes.
  function automatic logic [12:0] pick_offset(input logic [12:0] span);
    case ($urandom_range(3))
      0, 1:    return 13'($urandom_range(15));
      2:       return span - 13'($urandom_range(15));
      default: return 13'($urandom()) & span;
    endcase
  endfunction

  function automatic logic [15:0] window_address();
    logic [12:0] off;
    int unsigned w;
    w = $urandom_range(6);
    if (w == 5 || w == 6) begin
      off = pick_offset(13'h00FF);
      if (w == 5) return {bcsm_pkg::PAGE_DE, off[7:0]};
      return {bcsm_pkg::PAGE_DF, off[7:0]};
    end
    off = pick_offset(13'h1FFF);
    case (w)
      0:       return {bcsm_pkg::WIN_4000, off};
      1:       return {bcsm_pkg::WIN_6000, off};
      2:       return {bcsm_pkg::WIN_8000, off};
      3:       return {bcsm_pkg::WIN_A000, off};
      default: return {bcsm_pkg::WIN_E000, off};
    endcase
  endfunction

  // Mostly well-formed traffic: register writes, window writes and window
  // reads; the rest is full-range noise.
  function automatic bus_access_t random_access();
    bus_access_t a;
    int unsigned pick;
    a.op    = bcsm_pkg::OP_WRITE;
    a.addr  = 16'($urandom());
    a.wdata = 8'($urandom());
    a.obus  = 8'($urandom());
    pick    = $urandom_range(99);
    if (pick < 8) begin
      a.addr = {bcsm_pkg::PAGE_DE, a.addr[7:2], bcsm_pkg::REG_BANK};
    end else if (pick < 14) begin
      a.addr                           = {bcsm_pkg::PAGE_DE, a.addr[7:2], bcsm_pkg::REG_CTRL};
      a.wdata[bcsm_pkg::CtrlSramWeBit] = $urandom_range(3) != 0;
    end else if (pick < 44) begin
      a.addr = window_address();
    end else if (pick < 82) begin
      a.op   = bcsm_pkg::OP_READ;
      a.addr = window_address();
    end else begin
      a.op = 1'($urandom_range(1));
    end
    // The IO lock-out sticks until reset; keep it for the planned lock write
    if (a.op == bcsm_pkg::OP_WRITE && a.addr[15:8] == bcsm_pkg::PAGE_DE &&
        a.addr[1:0] == bcsm_pkg::REG_CTRL)
      a.wdata[bcsm_pkg::CtrlIoDisBit] = 1'b0;
    return a;
  endfunction

  // Offer one transaction at the falling edge, hold it until accepted, then
  // record its expected result. Valid stays high into the next call.
  task automatic offer_access(input bus_access_t a, input logic typed,
                              input bus_result_t typed_res);
    bus_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= a.op;
    bus_address_i    <= a.addr;
    write_data_i     <= a.wdata;
    open_bus_value_i <= a.obus;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    r = predict_bus_access(a);
    expected_bus_results.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s differs, expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Result side: random stall per phase, plus one long hold-off at the start
  // of the last phase so the block backs up and stalls its input.
  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall_i <= 1'b1;
      holdoff_left--;
    end else if (phase == 3 && !holdoff_done) begin
      holdoff_done = 1'b1;
      holdoff_left = HoldoffCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(99) < recv_idle_pct;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    bus_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bus_results.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got read_data 0x%0h",
                 $time, read_data_o);
        mismatches++;
      end else begin
        want = expected_bus_results.pop_front();
        check_field("read_data",   want.read_data,        read_data_o);
        check_field("drives_bus",  8'(want.drives_bus),   8'(drives_bus_o));
        check_field("write_route", 8'(want.write_route),  8'(write_route_o));
        check_field("sram_stored", 8'(want.sram_stored),  8'(sram_stored_o));
        check_field("game_line",   8'(want.game),         8'(game_line_o));
        check_field("exrom_line",  8'(want.exrom),        8'(exrom_line_o));
        check_field("memory_mode", 8'(want.mode),         8'(memory_mode_o));
        check_field("rom_bank",    8'(want.bank),         8'(rom_bank_o));
      end
    end
  end

  // Watchdog: end the run after too many cycles with no transaction on
  // either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bus_access_t a;
    foreach (sram_mirror[k]) sram_mirror[k] = '0;

    // Directed table. Typed-in rows: state right after reset and the first
    // register writes. Bank 0x1F selects the upper 16K half for the early
    // stores; later rows flip the bank and step through every memory mode.
    directed_rows.push_back(known_row(bcsm_pkg::OP_READ,  16'h0000, 8'h00, 8'hFF,
                                      8'hFF, 1'b0, 1'b0, 1'b0, bcsm_pkg::MODE_16K, 5'h00));
    directed_rows.push_back(known_row(bcsm_pkg::OP_READ,  16'hDFFF, 8'h00, 8'h5A,
                                      8'h00, 1'b1, 1'b0, 1'b0, bcsm_pkg::MODE_16K, 5'h00));
    directed_rows.push_back(known_row(bcsm_pkg::OP_WRITE, 16'hDE02, 8'hFF, 8'h00,
                                      8'h00, 1'b1, 1'b0, 1'b0, bcsm_pkg::MODE_16K, 5'h1F));
    directed_rows.push_back(known_row(bcsm_pkg::OP_WRITE, 16'hDEFF, 8'h10, 8'h00,
                                      8'h00, 1'b1, 1'b0, 1'b0, bcsm_pkg::MODE_16K, 5'h1F));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'h4000, 8'h11, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'h6000, 8'h33, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'hBFFF, 8'h44, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'h9FFF, 8'h55, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'hDF00, 8'h66, 8'h00));
    // IO1 offset zero with registers live: not a register, not storable
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'hDE00, 8'h77, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'hDE02, 8'hE0, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'h8000, 8'hAA, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'hDE03, 8'h30, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_READ,  16'h8000, 8'h00, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_READ,  16'hBFFF, 8'h00, 8'hC3));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'hDE02, 8'h01, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_READ,  16'hBFFF, 8'h00, 8'h3C));
    // 8K mode: high window and Ultimax window return SRAM but do not drive
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'hDE03, 8'h70, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_READ,  16'hA000, 8'h00, 8'h81));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_READ,  16'hE000, 8'h00, 8'h18));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'hDE03, 8'hB0, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_READ,  16'hFFFF, 8'h00, 8'hFF));
    // Mapped: the IO window does not take writes
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'hDF10, 8'h99, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_WRITE, 16'hDE03, 8'hD0, 8'h00));
    directed_rows.push_back(plain_row(bcsm_pkg::OP_READ,  16'hDF00, 8'h00, 8'h00));

    // Hold reset, then release it away from the active edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      offer_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].res);

    for (int i = 0; i < NumRandom; i++) begin
      if (i == 0) begin
        phase = 1; send_idle_pct = 15; recv_idle_pct = 51;
      end else if (i == NumRandom / 3) begin
        phase = 2; send_idle_pct = 51; recv_idle_pct = 15;
      end else if (i == 2 * NumRandom / 3) begin
        phase = 3; send_idle_pct = 0;  recv_idle_pct = 0;
      end
      if (i == NumRandom - 60) begin
        // Lock out the IO registers with writes enabled and SRAM unmapped,
        // so the remaining IO1 writes land in SRAM
        a                                = random_access();
        a.op                             = bcsm_pkg::OP_WRITE;
        a.addr                           = {bcsm_pkg::PAGE_DE, a.addr[7:2], bcsm_pkg::REG_CTRL};
        a.wdata[bcsm_pkg::CtrlIoDisBit]  = 1'b1;
        a.wdata[bcsm_pkg::CtrlSramWeBit] = 1'b1;
        a.wdata[bcsm_pkg::CtrlMappedBit] = 1'b0;
      end else begin
        a = random_access();
      end
      offer_access(a, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Drain the pipeline, then watch a few more edges for stray results
    while (expected_bus_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d bus transactions: %0d reads, %0d writes, %0d stored into SRAM.",
             reads_seen + writes_seen, reads_seen, writes_seen, stored_seen);
    $display("Swept bank halves and memory modes, a %0d-cycle result hold-off, IO lock-out.",
             HoldoffCycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
